// File: src/ffa_pkg.sv
// Shared constants and codes for the first-fit arena allocator.
package ffa_pkg;

  // Default arena geometry.
  localparam int ARENA_BYTES_DEF  = 16384;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int ALIGN_SHIFT_DEF  = 3;

  // Field widths fixed by the channel definitions.
  localparam int SIZE_W   = 15;
  localparam int STATUS_W = 2;
  localparam int MIN_W    = 11;
  localparam int CFG_IX_W = 1;
  localparam int CFG_D_W  = 11;
  // Working width for rounded requests, offsets and compares.
  localparam int REQ_W    = 18;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  // Request function codes.
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IX_W-1:0] CFG_MIN_ALLOC = 1'b0;
  localparam logic [CFG_IX_W-1:0] CFG_MERGE_EN  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [MIN_W-1:0] MIN_ALLOC_RST = 11'd16;
  localparam logic             MERGE_EN_RST  = 1'b1;

endpackage

// File: src/ffa_if.sv
// Valid/ready channel interfaces for requests and results.
interface ffa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [ffa_pkg::SIZE_W-1:0]    req_size;
  logic [ffa_pkg::SIZE_W-1:0]    free_addr;

  modport source (output valid, func, req_size, free_addr, input ready);
  modport sink   (input valid, func, req_size, free_addr, output ready);
endinterface

interface ffa_out_if;
  logic                          valid;
  logic                          ready;
  logic [ffa_pkg::STATUS_W-1:0]  status;
  logic [ffa_pkg::SIZE_W-1:0]    grant_addr;

  modport source (output valid, status, grant_addr, input ready);
  modport sink   (input valid, status, grant_addr, output ready);
endinterface

// File: src/ffa_hdr_ram.sv
// Block header table: one write port, one registered read port, entry 0 preset at reset.
module ffa_hdr_ram #(
  parameter int             DEPTH = 1025,
  parameter int             XW    = 11,
  parameter int             EW    = 16,
  parameter logic [EW-1:0]  RST_ENTRY = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [XW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [XW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] q_r;
  logic          zero_ok_r;
  logic          rd_rst_r;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  // Entry 0 reads as the reset block until it is first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_ok_r <= 1'b0;
      rd_rst_r  <= 1'b0;
    end else begin
      if (we && waddr == '0) begin
        zero_ok_r <= 1'b1;
      end
      rd_rst_r <= (raddr == '0) && !zero_ok_r;
    end
  end

  assign rdata = rd_rst_r ? RST_ENTRY : q_r;

endmodule

// File: src/first_fit_arena_allocator_top.sv
// First-fit arena allocator: header table walk, split, free and coalescing.
//
//  Channel | Dir | Beat payload                     | Handshake
//  in_if   | in  | func, req_size, free_addr        | valid/ready
//  out_if  | out | status, grant_addr               | valid/ready
//  cfg_*   | in  | cfg_idx, cfg_wdata               | cfg_we, no wait
//
// A request walks the header table one block per cycle from the lowest address.
// An allocate then moves every block above the taken one up by one entry, top first,
// and writes the split: the free remainder, then the used block. A free with merging
// enabled adds one compaction pass over the table; all steps share the single table port.
// Synchronous reset leaves one free block over the arena at once, with no clearing pass.
// One request is worked on at a time; a result waiting on out_if.ready does not stop the
// next beat being taken on in_if; that request then waits in S_DONE for the hand-off.
module first_fit_arena_allocator_top #(
  parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int ALIGN_SHIFT  = ffa_pkg::ALIGN_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ffa_in_if.sink                         in_if,
  ffa_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [ffa_pkg::CFG_IX_W-1:0]   cfg_idx,
  input  logic [ffa_pkg::CFG_D_W-1:0]    cfg_wdata
);

  localparam int AW   = $clog2(ARENA_BYTES + 1);
  localparam int EW   = AW + 1;
  localparam int MAXB = ARENA_BYTES / HEADER_BYTES + 1;
  localparam int XW   = $clog2(MAXB);
  localparam int CNW  = $clog2(MAXB + 1);
  localparam int RW   = ffa_pkg::REQ_W;
  localparam logic [EW-1:0] RST_ENTRY = {1'b0, AW'(ARENA_BYTES - HEADER_BYTES)};
  localparam logic [RW-1:0] HDR_R     = RW'(HEADER_BYTES);
  localparam logic [AW-1:0] HDR_A     = AW'(HEADER_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WALK  = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_INS   = 4'd3;
  localparam logic [3:0] S_INS2  = 4'd4;
  localparam logic [3:0] S_C0    = 4'd5;
  localparam logic [3:0] S_COAL  = 4'd6;
  localparam logic [3:0] S_CFIN  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                      state_r, state_nxt;
  logic [XW-1:0]                   idx_r, idx_nxt;
  logic [AW-1:0]                   start_r, start_nxt;
  logic [CNW-1:0]                  cnt_r, cnt_nxt;
  logic [RW-1:0]                   rnd_r, rnd_nxt;
  logic [RW-1:0]                   need_r, need_nxt;
  logic                            func_r, func_nxt;
  logic [ffa_pkg::SIZE_W-1:0]      addr_r, addr_nxt;
  logic                            addr_ok_r, addr_ok_nxt;
  logic [XW-1:0]                   f_r, f_nxt;
  logic [AW-1:0]                   fstart_r, fstart_nxt;
  logic [AW-1:0]                   rem_r, rem_nxt;
  logic [XW-1:0]                   sh_r, sh_nxt;
  logic [XW-1:0]                   w_r, w_nxt;
  logic [AW-1:0]                   pend_size_r, pend_size_nxt;
  logic                            pend_used_r, pend_used_nxt;
  logic [ffa_pkg::STATUS_W-1:0]    res_st_r, res_st_nxt;
  logic [ffa_pkg::SIZE_W-1:0]      res_gr_r, res_gr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [ffa_pkg::STATUS_W-1:0]    out_st_r, out_st_nxt;
  logic [ffa_pkg::SIZE_W-1:0]      out_gr_r, out_gr_nxt;
  logic [ffa_pkg::MIN_W-1:0]       min_r;
  logic                            merge_r;

  logic          ram_we;
  logic [XW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [XW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [AW-1:0] wk_size;
  logic          wk_used;
  logic          fits;
  logic          last;
  logic          hit;
  logic [RW-1:0] req_w;
  logic [RW-1:0] rnd_c;
  logic [RW-1:0] grant_w;

  ffa_hdr_ram #(
    .DEPTH     (MAXB),
    .XW        (XW),
    .EW        (EW),
    .RST_ENTRY (RST_ENTRY)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry under inspection and walk tests.
  assign wk_size = ram_rdata[AW-1:0];
  assign wk_used = ram_rdata[AW];
  assign fits    = !wk_used && (RW'(wk_size) >= need_r);
  assign last    = (CNW'(idx_r) + CNW'(1)) == cnt_r;
  assign hit     = addr_ok_r && ((RW'(start_r) + HDR_R) == RW'(addr_r));
  assign grant_w = RW'(fstart_r) + HDR_R;

  // Request rounding: raise to the minimum, else round up to the alignment.
  assign req_w = RW'(in_if.req_size);
  always_comb begin
    if (req_w < RW'(min_r)) begin
      rnd_c = RW'(min_r);
    end else if (req_w[ALIGN_SHIFT-1:0] != '0) begin
      rnd_c = ((req_w >> ALIGN_SHIFT) + RW'(1)) << ALIGN_SHIFT;
    end else begin
      rnd_c = req_w;
    end
  end

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_st_r;
  assign out_if.grant_addr = out_gr_r;

  // Sequencer: walk, shift, insert and compaction passes over the table.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    need_nxt      = need_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    addr_ok_nxt   = addr_ok_r;
    f_nxt         = f_r;
    fstart_nxt    = fstart_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    w_nxt         = w_r;
    pend_size_nxt = pend_size_r;
    pend_used_nxt = pend_used_r;
    res_st_nxt    = res_st_r;
    res_gr_nxt    = res_gr_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_gr_nxt    = out_gr_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          func_nxt    = in_if.func;
          addr_nxt    = in_if.free_addr;
          addr_ok_nxt = (in_if.free_addr != '0) &&
                        (RW'(in_if.free_addr) < RW'(ARENA_BYTES));
          rnd_nxt     = rnd_c;
          need_nxt    = rnd_c + HDR_R;
          idx_nxt     = '0;
          start_nxt   = '0;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        ram_raddr = idx_r + XW'(1);
        if (func_r == ffa_pkg::FN_ALLOC) begin
          if (fits) begin
            if (cnt_r >= CNW'(MAXB)) begin
              res_st_nxt = ffa_pkg::ST_NOFIT;
              res_gr_nxt = '0;
              state_nxt  = S_DONE;
            end else begin
              f_nxt      = idx_r;
              fstart_nxt = start_r;
              rem_nxt    = wk_size - AW'(need_r);
              if (last) begin
                state_nxt = S_INS;
              end else begin
                ram_raddr = XW'(cnt_r - CNW'(1));
                sh_nxt    = XW'(cnt_r - CNW'(1));
                state_nxt = S_SHIFT;
              end
            end
          end else if (last) begin
            res_st_nxt = ffa_pkg::ST_NOFIT;
            res_gr_nxt = '0;
            state_nxt  = S_DONE;
          end else begin
            idx_nxt   = idx_r + XW'(1);
            start_nxt = start_r + HDR_A + wk_size;
          end
        end else begin
          if (hit) begin
            res_gr_nxt = '0;
            if (wk_used) begin
              ram_we     = 1'b1;
              ram_waddr  = idx_r;
              ram_wdata  = {1'b0, wk_size};
              res_st_nxt = ffa_pkg::ST_OK;
              state_nxt  = merge_r ? S_C0 : S_DONE;
            end else begin
              res_st_nxt = ffa_pkg::ST_BADFREE;
              state_nxt  = S_DONE;
            end
          end else if (last) begin
            res_st_nxt = ffa_pkg::ST_BADFREE;
            res_gr_nxt = '0;
            state_nxt  = S_DONE;
          end else begin
            idx_nxt   = idx_r + XW'(1);
            start_nxt = start_r + HDR_A + wk_size;
          end
        end
      end
      // Move entries above the split point up by one, top first.
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = sh_r + XW'(1);
        ram_wdata = ram_rdata;
        if (sh_r == f_r + XW'(1)) begin
          state_nxt = S_INS;
        end else begin
          ram_raddr = sh_r - XW'(1);
          sh_nxt    = sh_r - XW'(1);
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = f_r + XW'(1);
        ram_wdata = {1'b0, rem_r};
        state_nxt = S_INS2;
      end
      S_INS2: begin
        ram_we     = 1'b1;
        ram_waddr  = f_r;
        ram_wdata  = {1'b1, AW'(rnd_r)};
        cnt_nxt    = cnt_r + CNW'(1);
        res_st_nxt = ffa_pkg::ST_OK;
        res_gr_nxt = grant_w[ffa_pkg::SIZE_W-1:0];
        state_nxt  = S_DONE;
      end
      // Compaction: read every entry in order, merge free runs, write back packed.
      S_C0: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        w_nxt     = '0;
        state_nxt = S_COAL;
      end
      S_COAL: begin
        ram_raddr = idx_r + XW'(1);
        if (idx_r == '0) begin
          pend_size_nxt = wk_size;
          pend_used_nxt = wk_used;
        end else if (!pend_used_r && !wk_used) begin
          pend_size_nxt = pend_size_r + wk_size + HDR_A;
        end else begin
          ram_we        = 1'b1;
          ram_waddr     = w_r;
          ram_wdata     = {pend_used_r, pend_size_r};
          w_nxt         = w_r + XW'(1);
          pend_size_nxt = wk_size;
          pend_used_nxt = wk_used;
        end
        if (last) begin
          state_nxt = S_CFIN;
        end else begin
          idx_nxt = idx_r + XW'(1);
        end
      end
      S_CFIN: begin
        ram_we    = 1'b1;
        ram_waddr = w_r;
        ram_wdata = {pend_used_r, pend_size_r};
        cnt_nxt   = CNW'(w_r) + CNW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_gr_nxt    = res_gr_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CNW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    start_r     <= start_nxt;
    rnd_r       <= rnd_nxt;
    need_r      <= need_nxt;
    func_r      <= func_nxt;
    addr_r      <= addr_nxt;
    addr_ok_r   <= addr_ok_nxt;
    f_r         <= f_nxt;
    fstart_r    <= fstart_nxt;
    rem_r       <= rem_nxt;
    sh_r        <= sh_nxt;
    w_r         <= w_nxt;
    pend_size_r <= pend_size_nxt;
    pend_used_r <= pend_used_nxt;
    res_st_r    <= res_st_nxt;
    res_gr_r    <= res_gr_nxt;
    out_st_r    <= out_st_nxt;
    out_gr_r    <= out_gr_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= ffa_pkg::MIN_ALLOC_RST;
      merge_r <= ffa_pkg::MERGE_EN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ffa_pkg::CFG_MIN_ALLOC: min_r   <= cfg_wdata[ffa_pkg::MIN_W-1:0];
        ffa_pkg::CFG_MERGE_EN:  merge_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/ffa_checker.sv
// Port-level checks for the allocator, bound to the top level.
module ffa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ffa_pkg::STATUS_W-1:0]  out_status,
  input logic [ffa_pkg::SIZE_W-1:0]    out_grant
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_grant))
    else $error("result beat changed while stalled");

  // One request at a time: no beat is taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ffa_pkg::ST_OK || out_status == ffa_pkg::ST_NOFIT ||
                   out_status == ffa_pkg::ST_BADFREE))
    else $error("undefined status");

  // A failed request grants nothing.
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffa_pkg::ST_OK |-> out_grant == '0)
    else $error("grant on failed request");

endmodule

bind first_fit_arena_allocator_top ffa_checker u_ffa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_grant  (out_if.grant_addr)
);
